/* rtl/npcs_pkg.sv */
// ----------------------------------------------------------------------------
// npcs_pkg: shared definitions for the nearest palette color search
// Widths, codes, state encoding and the small arithmetic helpers used by
// the sequencer and the distance unit.
// ----------------------------------------------------------------------------
package npcs_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int ADDR_W          = $clog2(PALETTE_ENTRIES);
   localparam int IDX_W           = 8;
   localparam int CHAN_W          = 8;
   localparam int DIST_W          = 18;
   localparam int BEST_W          = 19;
   localparam int CSR_DATA_W      = 8;

   localparam logic [BEST_W-1:0] START_DISTANCE = BEST_W'(256 * 256 * 4);
   localparam logic [IDX_W-1:0]  LAST_RESET     = IDX_W'(254);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic CSR_FIRST_INDEX = 1'b0;
   localparam logic CSR_LAST_INDEX  = 1'b1;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } npcs_rgb_type;

   typedef struct packed {
      logic             start;
      logic             valid;
      logic [IDX_W-1:0] index;
   } npcs_ctl_type;

   typedef struct packed {
      logic busy;
      logic hit;
   } npcs_status_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } npcs_state_type;

   function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

/* rtl/npcs_dist_unit.sv */
// ----------------------------------------------------------------------------
// npcs_dist_unit: squared distance and running minimum
// Two stages: squares of the channel differences, then the sum and the
// compare against the best entry so far. Lower index wins on a tie.
// ----------------------------------------------------------------------------
module npcs_dist_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  npcs_pkg::npcs_ctl_type         ctl,
   input  npcs_pkg::npcs_rgb_type         color,
   input  npcs_pkg::npcs_rgb_type         entry,
   output logic [npcs_pkg::IDX_W-1:0]     best_index,
   output logic [npcs_pkg::BEST_W-1:0]    best_distance,
   output npcs_pkg::npcs_status_type      status
);

   logic [2*npcs_pkg::CHAN_W-1:0] sq_red_ff;
   logic [2*npcs_pkg::CHAN_W-1:0] sq_green_ff;
   logic [2*npcs_pkg::CHAN_W-1:0] sq_blue_ff;
   logic [npcs_pkg::IDX_W-1:0]    sq_index_ff;
   logic                          sq_valid_ff;
   logic [npcs_pkg::CHAN_W-1:0]   d_red;
   logic [npcs_pkg::CHAN_W-1:0]   d_green;
   logic [npcs_pkg::CHAN_W-1:0]   d_blue;
   logic [npcs_pkg::DIST_W-1:0]   sum;
   logic [npcs_pkg::IDX_W-1:0]    best_index_ff;
   logic [npcs_pkg::BEST_W-1:0]   best_dist_ff;

   assign d_red   = npcs_pkg::abs_diff(color.red,   entry.red);
   assign d_green = npcs_pkg::abs_diff(color.green, entry.green);
   assign d_blue  = npcs_pkg::abs_diff(color.blue,  entry.blue);

   always_ff @(posedge clock) begin
      sq_red_ff   <= d_red * d_red;
      sq_green_ff <= d_green * d_green;
      sq_blue_ff  <= d_blue * d_blue;
      sq_index_ff <= ctl.index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff <= ctl.valid;
      end
   end

   assign sum = npcs_pkg::DIST_W'(sq_red_ff) + npcs_pkg::DIST_W'(sq_green_ff)
              + npcs_pkg::DIST_W'(sq_blue_ff);

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         best_dist_ff  <= npcs_pkg::START_DISTANCE;
         best_index_ff <= '0;
      end else if (sq_valid_ff && (npcs_pkg::BEST_W'(sum) < best_dist_ff)) begin
         best_dist_ff  <= npcs_pkg::BEST_W'(sum);
         best_index_ff <= sq_index_ff;
      end
   end

   assign best_index    = best_index_ff;
   assign best_distance = best_dist_ff;
   assign status.busy   = sq_valid_ff;
   assign status.hit    = (best_dist_ff == '0);

endmodule

/* rtl/nearest_palette_color_search.sv */
// ----------------------------------------------------------------------------
// nearest_palette_color_search: nearest palette entry by RGB distance
// Palette of RGB entries with a sequenced scan for the closest color.
// ----------------------------------------------------------------------------
// Usage:
//   A request on req_* either writes one palette entry (opcode write) or
//   runs a query (opcode query). Writes give no response.
//   A query scans entries first_index..last_index through one shared
//   distance unit, one entry per cycle, and gives one response on rsp_*.
//   The scan stops early at the first exact match. An empty range skips
//   the scan and goes straight to the finish state.
//   Throughput is set by the single palette read port feeding the distance
//   unit: one entry per cycle; the next query is taken only once the
//   previous one has left the finish state.
//   req_stall is high while a query is in flight. A finished response is
//   held in the output register while rsp_stall is high; writes and the next
//   query are taken meanwhile, and a second response waits in the finish
//   state until the register frees up.
//   Reset clears control state and the csr registers (first 0, last 254);
//   palette contents are undefined until written.
//   csr_* writes are only allowed while no query is in flight.
// ----------------------------------------------------------------------------
module nearest_palette_color_search (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic                              csr_index,
   input  logic [npcs_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_opcode,
   input  logic [npcs_pkg::IDX_W-1:0]        req_entry_index,
   input  logic [npcs_pkg::CHAN_W-1:0]       req_red,
   input  logic [npcs_pkg::CHAN_W-1:0]       req_green,
   input  logic [npcs_pkg::CHAN_W-1:0]       req_blue,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [npcs_pkg::IDX_W-1:0]        rsp_best_index,
   output logic [npcs_pkg::DIST_W-1:0]       rsp_best_distance,
   output logic                              rsp_range_empty
);

   npcs_pkg::npcs_state_type      state_ff;
   npcs_pkg::npcs_state_type      state_in;
   npcs_pkg::npcs_rgb_type        palette_mem [npcs_pkg::PALETTE_ENTRIES];
   npcs_pkg::npcs_rgb_type        rd_data_ff;
   npcs_pkg::npcs_rgb_type        color_ff;
   npcs_pkg::npcs_ctl_type        ctl;
   npcs_pkg::npcs_status_type     status;
   logic [npcs_pkg::IDX_W-1:0]    first_ff;
   logic [npcs_pkg::IDX_W-1:0]    last_ff;
   logic [npcs_pkg::ADDR_W-1:0]   hi_sat;
   logic                          range_empty;
   logic [npcs_pkg::ADDR_W-1:0]   addr_ff;
   logic [npcs_pkg::ADDR_W-1:0]   hi_ff;
   logic [npcs_pkg::IDX_W-1:0]    rd_index_ff;
   logic                          rd_valid_ff;
   logic                          empty_ff;
   logic                          req_accept;
   logic                          rsp_load;
   logic [npcs_pkg::IDX_W-1:0]    best_index;
   logic [npcs_pkg::BEST_W-1:0]   best_distance;
   logic                          rsp_valid_ff;
   logic [npcs_pkg::IDX_W-1:0]    rsp_index_ff;
   logic [npcs_pkg::DIST_W-1:0]   rsp_dist_ff;
   logic                          rsp_empty_ff;

   assign req_stall  = (state_ff != npcs_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = (state_ff == npcs_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         last_ff  <= npcs_pkg::LAST_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            npcs_pkg::CSR_FIRST_INDEX: first_ff <= csr_wr_data;
            npcs_pkg::CSR_LAST_INDEX:  last_ff  <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign hi_sat = (32'(last_ff) > npcs_pkg::PALETTE_ENTRIES - 1)
                 ? npcs_pkg::ADDR_W'(npcs_pkg::PALETTE_ENTRIES - 1)
                 : last_ff[npcs_pkg::ADDR_W-1:0];
   assign range_empty = (32'(first_ff) > 32'(hi_sat));

   // palette memory
   always_ff @(posedge clock) begin
      if (req_accept && (req_opcode == npcs_pkg::OP_WRITE)
          && (32'(req_entry_index) < npcs_pkg::PALETTE_ENTRIES)) begin
         palette_mem[req_entry_index[npcs_pkg::ADDR_W-1:0]] <= {req_red, req_green, req_blue};
      end
      rd_data_ff <= palette_mem[addr_ff];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         npcs_pkg::ST_IDLE: begin
            if (req_accept && (req_opcode == npcs_pkg::OP_QUERY)) begin
               state_in = range_empty ? npcs_pkg::ST_FINISH : npcs_pkg::ST_SCAN;
            end
         end
         npcs_pkg::ST_SCAN: begin
            if (status.hit || (addr_ff == hi_ff)) begin
               state_in = npcs_pkg::ST_DRAIN;
            end
         end
         npcs_pkg::ST_DRAIN: begin
            if (!rd_valid_ff && !status.busy) begin
               state_in = npcs_pkg::ST_FINISH;
            end
         end
         npcs_pkg::ST_FINISH: begin
            if (rsp_load) begin
               state_in = npcs_pkg::ST_IDLE;
            end
         end
         default: state_in = npcs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= npcs_pkg::ST_IDLE;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= (state_ff == npcs_pkg::ST_SCAN) && !status.hit;
      end
   end

   // advance the scan address; hold the query context
   always_ff @(posedge clock) begin
      if (req_accept && (req_opcode == npcs_pkg::OP_QUERY)) begin
         addr_ff  <= first_ff[npcs_pkg::ADDR_W-1:0];
         hi_ff    <= hi_sat;
         empty_ff <= range_empty;
         color_ff <= {req_red, req_green, req_blue};
      end else if (state_ff == npcs_pkg::ST_SCAN) begin
         addr_ff <= addr_ff + 1'b1;
      end
      rd_index_ff <= npcs_pkg::IDX_W'(addr_ff);
   end

   assign ctl.start = req_accept && (req_opcode == npcs_pkg::OP_QUERY);
   assign ctl.valid = rd_valid_ff;
   assign ctl.index = rd_index_ff;

   npcs_dist_unit u_dist (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .color         (color_ff),
      .entry         (rd_data_ff),
      .best_index    (best_index),
      .best_distance (best_distance),
      .status        (status)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_empty_ff <= empty_ff;
         rsp_index_ff <= empty_ff ? '0 : best_index;
         rsp_dist_ff  <= empty_ff ? '0 : best_distance[npcs_pkg::DIST_W-1:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_index    = rsp_index_ff;
   assign rsp_best_distance = rsp_dist_ff;
   assign rsp_range_empty   = rsp_empty_ff;

endmodule

/* rtl/npcs_checker.sv */
// ----------------------------------------------------------------------------
// npcs_checker: port-level checks for the nearest palette color search
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module npcs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              req_opcode,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [npcs_pkg::IDX_W-1:0]        rsp_best_index,
   input logic [npcs_pkg::DIST_W-1:0]       rsp_best_distance,
   input logic                              rsp_range_empty
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_best_index)
         && $stable(rsp_best_distance) && $stable(rsp_range_empty))
      else $error("stalled response changed");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_empty |-> (rsp_best_index == '0) && (rsp_best_distance == '0))
      else $error("empty range response not zero");

   a_dist_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_best_distance) <= 195075))
      else $error("distance out of range");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_opcode == npcs_pkg::OP_QUERY) |=> req_stall)
      else $error("query request not followed by stall");

   a_write_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_opcode == npcs_pkg::OP_WRITE) |=> !req_stall)
      else $error("write request stalled the channel");

endmodule

bind nearest_palette_color_search npcs_checker u_npcs_checker (.*);
